>>> rtl/sysex_seven_bit_block_codec_defines.svh
// ----------------------------------------------------------------------------
// sysex seven-bit block codec assertion macros
// concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef SYSEX_SEVEN_BIT_BLOCK_CODEC_DEFINES_SVH
`define SYSEX_SEVEN_BIT_BLOCK_CODEC_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define SYSEX7_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define SYSEX7_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SYSEX7_ASSERT_SAME(lbl, ante, cons)
`define SYSEX7_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/sysex7_pkg.sv
// ----------------------------------------------------------------------------
// sysex7_pkg
// shared constants and types of the seven-bit block codec
// ----------------------------------------------------------------------------
package sysex7_pkg;

    localparam int BLOCK_DATA = 7;
    localparam logic [2:0] LAST_DATA_IDX = 3'(BLOCK_DATA - 1);
    localparam logic [2:0] BLOCK_DATA_POS = 3'(BLOCK_DATA);

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // low seven bits of the held block bytes
    typedef logic [BLOCK_DATA-1:0][6:0] held_t;

    // one burst of result items
    typedef struct packed {
        logic       decode;
        logic [6:0] first_byte;
        logic [6:0] high_bits;
        logic       close;
        logic [2:0] last_idx;
        logic       stream_end;
    } job_t;

endpackage

>>> rtl/sysex7_if.sv
// ----------------------------------------------------------------------------
// sysex7 channel interfaces
// input item, result item and direction write channels
// ----------------------------------------------------------------------------
interface sysex7_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sysex7_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       block_end;
    logic       stream_end;

    modport source (output valid, output out_byte, output block_end, output stream_end,
                    input ready);
    modport sink (input valid, input out_byte, input block_end, input stream_end,
                  output ready);
endinterface

interface sysex7_cfg_if;
    logic valid;
    logic ready;
    logic direction;

    modport source (output valid, output direction, input ready);
    modport sink (input valid, input direction, output ready);
endinterface

>>> rtl/sysex7_burst.sv
// ----------------------------------------------------------------------------
// sysex7_burst
// holds one burst descriptor and emits its result items one per cycle while result.ready is high
// ----------------------------------------------------------------------------
module sysex7_burst (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  sysex7_pkg::job_t     job,
    input  sysex7_pkg::held_t    held,
    output logic                 free,
    sysex7_result_if.source      result
);

    logic             busy_reg;
    logic             busy_next;
    logic [2:0]       idx_reg;
    logic [2:0]       idx_next;
    sysex7_pkg::job_t job_reg;
    sysex7_pkg::job_t job_next;
    logic             at_end;
    logic             finishing;

    assign at_end    = (idx_reg == job_reg.last_idx);
    assign finishing = busy_reg && result.ready && at_end;
    assign free      = !busy_reg || finishing;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        job_next  = job_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = 3'd0;
            job_next  = job;
        end
        else if (finishing)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && result.ready)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    always_comb
    begin
        result.valid      = busy_reg;
        result.stream_end = job_reg.stream_end;
        result.block_end  = job_reg.close && at_end;
        if (job_reg.decode)
        begin
            result.out_byte = {job_reg.high_bits[idx_reg], held[idx_reg]};
        end
        else if (idx_reg == 3'd0)
        begin
            result.out_byte = {1'b0, job_reg.first_byte};
        end
        else if (at_end)
        begin
            result.out_byte = {1'b0, job_reg.high_bits};
        end
        else
        begin
            result.out_byte = 8'd0;
        end
    end

endmodule

>>> rtl/sysex_seven_bit_block_codec.sv
// ----------------------------------------------------------------------------
// sysex_seven_bit_block_codec
// converts a byte stream to and from 8-byte blocks with bit 7 clear
// ----------------------------------------------------------------------------
// an accepted item passes the input register and then the burst register before its first result
// throughput: 1 item per cycle while each item yields at most one result and result.ready is high;
//   a burst of n results holds the result stage until all n are taken (up to 8 when
//   encoding a closing byte, 7 when decoding the high-bit byte)
// the burst emitter, one result per cycle while result.ready is high, sets the sustained rate
// reset: rst_n asynchronous active low, clears direction, position, high bits
//   and all valid flags; held bytes are not cleared
// ----------------------------------------------------------------------------
`include "sysex_seven_bit_block_codec_defines.svh"

module sysex_seven_bit_block_codec (
    input  logic            clk,
    input  logic            rst_n,
    sysex7_byte_if.sink     item,
    sysex7_result_if.source result,
    sysex7_cfg_if.sink      cfg
);

    // direction register and block tracking state
    logic              direction_reg;
    logic              direction_next;
    logic [2:0]        position_reg;
    logic [2:0]        position_next;
    logic [6:0]        high_bits_reg;
    logic [6:0]        high_bits_next;
    sysex7_pkg::held_t held_reg;
    sysex7_pkg::held_t held_next;

    // input register: parts the item channel from the burst emitter
    logic              pend_valid_reg;
    logic [7:0]        pend_byte_reg;
    logic              pend_last_reg;

    logic              burst_free;
    logic              move;
    logic              load;
    sysex7_pkg::job_t  job;

    // encode helpers
    logic [2:0]        enc_pos;
    logic [2:0]        enc_pos_inc;
    logic [6:0]        enc_high;
    logic              enc_close;

    // pending item goes into the emitter when it is idle or draining its last result
    assign move       = pend_valid_reg && burst_free;
    assign item.ready = !pend_valid_reg || move;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (item.valid && item.ready)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (move)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            pend_byte_reg <= item.data_byte;
            pend_last_reg <= item.last_byte;
        end
    end

    // encode: current slot, bit 7 collected into the high-bit byte
    assign enc_pos     = (position_reg >= sysex7_pkg::BLOCK_DATA_POS) ? 3'd0 : position_reg;
    assign enc_high    = high_bits_reg | (7'(pend_byte_reg[7]) << enc_pos);
    assign enc_pos_inc = enc_pos + 3'd1;
    assign enc_close   = (enc_pos_inc == sysex7_pkg::BLOCK_DATA_POS) || pend_last_reg;

    always_comb
    begin
        direction_next = direction_reg;
        position_next  = position_reg;
        high_bits_next = high_bits_reg;
        held_next      = held_reg;
        load           = 1'b0;
        job            = '0;
        job.stream_end = pend_last_reg;

        if (cfg.valid && cfg.ready)
        begin
            // a direction write abandons any block in progress
            direction_next = cfg.direction;
            position_next  = 3'd0;
            high_bits_next = 7'd0;
        end
        else if (move)
        begin
            if (direction_reg == sysex7_pkg::DIR_ENCODE)
            begin
                // data byte, then zero pads and high-bit byte when the block closes
                load           = 1'b1;
                job.decode     = 1'b0;
                job.first_byte = pend_byte_reg[6:0];
                job.high_bits  = enc_high;
                job.close      = enc_close;
                job.last_idx   = enc_close ? 3'(4'd8 - {1'b0, enc_pos_inc}) : 3'd0;
                position_next  = enc_close ? 3'd0 : enc_pos_inc;
                high_bits_next = enc_close ? 7'd0 : enc_high;
            end
            else if (position_reg < sysex7_pkg::BLOCK_DATA_POS)
            begin
                // hold a data byte; a final byte here drops the partial block
                held_next[position_reg] = pend_byte_reg[6:0];
                position_next = pend_last_reg ? 3'd0 : (position_reg + 3'd1);
            end
            else
            begin
                // high-bit byte releases the seven restored bytes
                load          = 1'b1;
                job.decode    = 1'b1;
                job.high_bits = pend_byte_reg[6:0];
                job.close     = 1'b1;
                job.last_idx  = sysex7_pkg::LAST_DATA_IDX;
                position_next = 3'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= sysex7_pkg::DIR_ENCODE;
            position_reg  <= 3'd0;
            high_bits_reg <= 7'd0;
        end
        else
        begin
            direction_reg <= direction_next;
            position_reg  <= position_next;
            high_bits_reg <= high_bits_next;
        end
    end

    // held bytes are only read after being written within the same block
    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

    sysex7_burst u_burst (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .job    (job),
        .held   (held_reg),
        .free   (burst_free),
        .result (result)
    );

    // encoded bytes never carry bit 7
    `SYSEX7_ASSERT_SAME(a_enc_seven_bit,
        result.valid && (direction_reg == sysex7_pkg::DIR_ENCODE),
        !result.out_byte[7])
    // every encoded item produces at least one result
    `SYSEX7_ASSERT_NEXT(a_enc_yields,
        move && (direction_reg == sysex7_pkg::DIR_ENCODE) && !cfg.valid,
        result.valid)
    // encode position always stays inside the block
    `SYSEX7_ASSERT_SAME(a_enc_position,
        direction_reg == sysex7_pkg::DIR_ENCODE,
        position_reg < sysex7_pkg::BLOCK_DATA_POS)

endmodule
